// File: rtl/scm_pkg.sv
// Shared constants and types of the stereo correlation meter.
package scm_pkg;

	localparam int MaxFrames  = 4096;
	localparam int SampleBits = 16;
	localparam int CountW     = $clog2(MaxFrames + 1);
	localparam int SqW        = 2 * SampleBits + CountW - 2;
	localparam int CrossW     = SqW + 1;
	localparam int WideW      = 64;
	localparam int DivW       = 66;

	localparam logic [15:0] SlowAlphaReset = 16'd65077;
	localparam logic [15:0] FastAlphaReset = 16'd52429;

	// Configuration register indexes.
	localparam logic [0:0] RegSlowAlpha = 1'b0;
	localparam logic [0:0] RegFastAlpha = 1'b1;

	// Input operation codes.
	localparam logic OpFrame = 1'b0;
	localparam logic OpTick  = 1'b1;

	// Datapath command, issued by the controller.
	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_FRAME,
		CMD_LOAD,
		CMD_SQRT_LR,
		CMD_SQRT_STEP,
		CMD_MUL_DEN,
		CMD_DIV_COR_INIT,
		CMD_DIV_STEP,
		CMD_COR_DONE,
		CMD_WIDTH_INIT,
		CMD_WIDTH_DONE,
		CMD_BAL_SQRT,
		CMD_BAL_DIV_INIT,
		CMD_BAL_DONE,
		CMD_SMOOTH,
		CMD_FINISH
	} cmd_t;

	typedef struct packed {
		cmd_t       cmd;
		logic [1:0] sqrt_sel;
	} dp_ctrl_t;

	typedef struct packed {
		logic have_frames;
		logic unit_busy;
	} dp_stat_t;

endpackage

// File: rtl/stereo_correlation_meter.sv
// Top level of the stereo correlation meter.
// Input beats on s_axis: tuser = op (0 frame, 1 tick), tdata = left and right samples.
// A frame beat adds its squares and product to the sums when it is taken;
// frames can follow back to back, and frames past 4096 in one window are dropped.
// A tick beat starts the analysis sequence run by the controller: two 32-step
// square roots, an 82-step divide for the correlation, a 32-step root for the
// width, two more roots and a 66-step divide for the balance, then the width,
// correlation and balance smoothers in turn; a tick without frames goes straight to the smoothers.
// No input is taken while the analysis runs.
// Each tick yields one beat on m_axis holding width, correlation and balance.
// The result sits in an output register. Frames are still taken while it waits;
// a later tick runs its analysis and then holds, blocking input, until the
// receiver has taken the earlier beat. Reset clears all sums, the smoothers and
// loads the default smoothing coefficients; no clearing pass is needed.
// Configuration writes on cfg_we/cfg_index/cfg_data take effect at once.
module stereo_correlation_meter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // left_sample[15:0], right_sample[31:16]
	input  logic        s_axis_tuser,  // op
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // width_out[14:0], correlation_out[30:15], balance_out[46:31]
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import scm_pkg::*;

	dp_ctrl_t ctrl;
	dp_stat_t stat;
	logic [15:0] slow_alpha, fast_alpha;
	logic [14:0] width_out;
	logic signed [15:0] correlation_out, balance_out;

	scm_cfg_regs u_cfg (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data, .slow_alpha, .fast_alpha
	);

	scm_controller u_ctl (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_op(s_axis_tuser), .in_ready(s_axis_tready),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.stat, .ctrl
	);

	scm_datapath u_dp (
		.clk, .arst_n, .ctrl,
		.left_sample(s_axis_tdata[15:0]), .right_sample(s_axis_tdata[31:16]),
		.slow_alpha, .fast_alpha, .stat,
		.width_out, .correlation_out, .balance_out
	);

	assign m_axis_tdata = {1'b0, balance_out, correlation_out, width_out};
endmodule

// File: rtl/scm_datapath.sv
// Datapath of the stereo correlation meter: sums, root and divide units, smoothers.
module scm_datapath (
	input  logic                   clk,
	input  logic                   arst_n,
	input  scm_pkg::dp_ctrl_t      ctrl,
	input  logic signed [15:0]     left_sample,
	input  logic signed [15:0]     right_sample,
	input  logic [15:0]            slow_alpha,
	input  logic [15:0]            fast_alpha,
	output scm_pkg::dp_stat_t      stat,
	output logic [14:0]            width_out,
	output logic signed [15:0]     correlation_out,
	output logic signed [15:0]     balance_out
);
	import scm_pkg::*;

	logic [SqW-1:0]            sum_l_q, sum_r_q;
	logic signed [CrossW-1:0]  sum_x_q;
	logic [CountW-1:0]         count_q;
	logic signed [16:0]        sm_w_q, sm_c_q, sm_b_q;

	// Output register, loaded when the receiver side is free.
	logic [14:0]               res_w_q;
	logic signed [15:0]        res_c_q, res_b_q;

	// Working registers of the tick sequence.
	logic [WideW-1:0] sq_v_q, sq_r_q, sq_bit_q;
	logic [31:0]      sl_q, sr_q;
	logic [4:0]       na_q, nb_q;
	logic [DivW-1:0]  num_q, den_q, rem_q, quo_q;
	logic [6:0]       dcnt_q;
	logic signed [17:0] cc_q, cw_q, cb_q;
	logic             neg_q, bal_neg_q;
	logic [1:0]       sm_step_q;

	// Sample squares and cross product.
	logic signed [SampleBits-1:0] ls, rs;
	logic signed [2*SampleBits-1:0] pll, prr, plr;
	assign ls  = left_sample[SampleBits-1:0];
	assign rs  = right_sample[SampleBits-1:0];
	assign pll = ls * ls;
	assign prr = rs * rs;
	assign plr = ls * rs;

	// Two-bit normalization count toward a lower bound; each step is an independent compare.
	function automatic logic [4:0] norm_steps(input logic [63:0] v, input int lb);
		logic [4:0] k;
		k = '0;
		for (int i = 0; i < 30; i++) begin
			if (v < (64'd1 << (lb - 2 - 2 * i)))
				k = k + 5'd1;
		end
		return k;
	endfunction

	logic [63:0] l64, r64, m64;
	assign l64 = 64'(sum_l_q);
	assign r64 = 64'(sum_r_q);
	assign m64 = (l64 > r64) ? l64 : r64;

	// One step of the shared restoring square root.
	logic [WideW-1:0] sq_t;
	assign sq_t = sq_r_q + sq_bit_q;

	// One step of the shared restoring divider.
	logic [DivW-1:0] rem_sh;
	assign rem_sh = {rem_q[DivW-2:0], num_q[DivW-1]};

	// Smoother operands, one of three per cycle.
	logic signed [17:0] sm_s, sm_x;
	logic [15:0]        sm_a;
	logic signed [52:0] sm_n;
	logic signed [36:0] sm_qv;
	logic signed [16:0] sm_lo, sm_hi, sm_res;
	always_comb begin
		case (sm_step_q)
			2'd0: begin
				sm_s = 18'(sm_w_q); sm_x = cw_q; sm_a = slow_alpha;
				sm_lo = 17'sd0; sm_hi = 17'sd32767;
			end
			2'd1: begin
				sm_s = 18'(sm_c_q); sm_x = cc_q; sm_a = fast_alpha;
				sm_lo = -17'sd32768; sm_hi = 17'sd32767;
			end
			default: begin
				sm_s = 18'(sm_b_q); sm_x = cb_q; sm_a = slow_alpha;
				sm_lo = -17'sd32768; sm_hi = 17'sd32767;
			end
		endcase
		sm_n = 53'(sm_s * $signed({1'b0, sm_a}))
			+ 53'(sm_x * $signed({1'b0, 17'h10000 - 17'(sm_a)})) + 53'sd32768;
		sm_qv = 37'(sm_n >>> 16);
		if (sm_qv < 37'(sm_lo))
			sm_res = sm_lo;
		else if (sm_qv > 37'(sm_hi))
			sm_res = sm_hi;
		else
			sm_res = sm_qv[16:0];
	end

	// The quotients carry 16 fraction bits; round to Q.15 and cap the correlation at one.
	logic [DivW-1:0] cor_val, bal_val;
	assign cor_val = (|quo_q[DivW-1:16]) ? DivW'(32768) : ((quo_q + 66'd1) >> 1);
	assign bal_val = (quo_q + 66'd1) >> 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_l_q <= '0;
			sum_r_q <= '0;
			sum_x_q <= '0;
			count_q <= '0;
			sm_w_q <= '0;
			sm_c_q <= '0;
			sm_b_q <= '0;
			res_w_q <= '0;
			res_c_q <= '0;
			res_b_q <= '0;
			dcnt_q <= '0;
			sm_step_q <= '0;
		end else begin
			unique case (ctrl.cmd)
				CMD_FRAME: begin
					if (count_q < CountW'(MaxFrames)) begin
						sum_l_q <= sum_l_q + SqW'(unsigned'(pll));
						sum_r_q <= sum_r_q + SqW'(unsigned'(prr));
						sum_x_q <= sum_x_q + CrossW'(plr);
						count_q <= count_q + 1'b1;
					end
				end
				CMD_LOAD: begin
					// Defaults for a tick without frames.
					cw_q <= '0;
					cc_q <= 18'sd32768;
					cb_q <= '0;
					sm_step_q <= '0;
					na_q <= norm_steps(l64, 60);
					nb_q <= norm_steps(r64, 60);
					neg_q <= sum_x_q < 0;
				end
				CMD_SQRT_LR: begin
					// Start a root of the selected operand.
					unique case (ctrl.sqrt_sel)
						2'd0: sq_v_q <= l64 << (2 * na_q);
						2'd1: sq_v_q <= r64 << (2 * nb_q);
						2'd2: sq_v_q <= l64 << (2 * na_q);
						default: sq_v_q <= r64 << (2 * na_q);
					endcase
					sq_r_q <= '0;
					sq_bit_q <= 64'd1 << 62;
					dcnt_q <= 7'd32;
				end
				CMD_SQRT_STEP: begin
					if (sq_v_q >= sq_t) begin
						sq_v_q <= sq_v_q - sq_t;
						sq_r_q <= (sq_r_q >> 1) + sq_bit_q;
					end else begin
						sq_r_q <= sq_r_q >> 1;
					end
					sq_bit_q <= sq_bit_q >> 2;
					dcnt_q <= dcnt_q - 7'd1;
					if (dcnt_q == 7'd1) begin
						unique case (ctrl.sqrt_sel)
							2'd0, 2'd2: sl_q <= 32'(sq_v_q >= sq_t ?
								(sq_r_q >> 1) + sq_bit_q : sq_r_q >> 1);
							default: sr_q <= 32'(sq_v_q >= sq_t ?
								(sq_r_q >> 1) + sq_bit_q : sq_r_q >> 1);
						endcase
					end
				end
				CMD_MUL_DEN: begin
					den_q <= DivW'(sl_q * sr_q);
				end
				CMD_DIV_COR_INIT: begin
					// Sixteen extra steps shift in zeros for the fraction bits.
					num_q <= DivW'(neg_q ? -sum_x_q : sum_x_q) << (6'(na_q) + 6'(nb_q));
					rem_q <= '0;
					quo_q <= '0;
					dcnt_q <= 7'(DivW + 16);
				end
				CMD_DIV_STEP: begin
					num_q <= num_q << 1;
					if (rem_sh >= den_q) begin
						rem_q <= rem_sh - den_q;
						quo_q <= {quo_q[DivW-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						quo_q <= {quo_q[DivW-2:0], 1'b0};
					end
					dcnt_q <= dcnt_q - 7'd1;
				end
				CMD_COR_DONE: begin
					if (sum_l_q == '0 || sum_r_q == '0)
						cc_q <= 18'sd32768;
					else
						cc_q <= neg_q ? -18'(cor_val) : 18'(cor_val);
				end
				CMD_WIDTH_INIT: begin
					// A negative correlation gives the widest image.
					sq_v_q <= (cc_q < 0) ? 64'd32768 << 17 : 64'(18'sd32768 - cc_q) << 17;
					sq_r_q <= '0;
					sq_bit_q <= 64'd1 << 62;
					dcnt_q <= 7'd32;
				end
				CMD_WIDTH_DONE: begin
					cw_q <= 18'((sq_r_q + 64'd1) >> 1);
					na_q <= norm_steps(m64, 62);
				end
				CMD_BAL_DIV_INIT: begin
					bal_neg_q <= sl_q > sr_q;
					num_q <= DivW'(sr_q >= sl_q ? sr_q - sl_q : sl_q - sr_q) << 16;
					den_q <= DivW'(sl_q) + DivW'(sr_q);
					rem_q <= '0;
					quo_q <= '0;
					dcnt_q <= 7'(DivW);
				end
				CMD_BAL_DONE: begin
					if (m64 == '0)
						cb_q <= '0;
					else
						cb_q <= bal_neg_q ? -18'(bal_val) : 18'(bal_val);
					sum_l_q <= '0;
					sum_r_q <= '0;
					sum_x_q <= '0;
					count_q <= '0;
				end
				CMD_SMOOTH: begin
					unique case (sm_step_q)
						2'd0: sm_w_q <= sm_res;
						2'd1: sm_c_q <= sm_res;
						default: sm_b_q <= sm_res;
					endcase
					sm_step_q <= sm_step_q + 2'd1;
				end
				CMD_FINISH: begin
					res_w_q <= sm_w_q[14:0];
					res_c_q <= sm_c_q[15:0];
					res_b_q <= sm_b_q[15:0];
				end
				default: ;
			endcase
		end
	end

	assign stat.have_frames = count_q != '0;
	assign stat.unit_busy   = dcnt_q != '0;
	assign width_out        = res_w_q;
	assign correlation_out  = res_c_q;
	assign balance_out      = res_b_q;

	// The frame count never passes its ceiling.
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CountW'(MaxFrames)) else $error("frame count overflow");
	// Smoothed width stays non-negative.
	a_width_pos: assert property (@(posedge clk) disable iff (!arst_n)
		sm_w_q >= 0) else $error("negative width");
	// A finished tick leaves the frame count cleared.
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.cmd == CMD_BAL_DONE |=> count_q == '0) else $error("sums not cleared");
endmodule

// File: rtl/scm_controller.sv
// Controller of the stereo correlation meter: handshake and tick sequencing.
module scm_controller (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_op,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  scm_pkg::dp_stat_t   stat,
	output scm_pkg::dp_ctrl_t   ctrl
);
	import scm_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_LOAD, S_SQ_START, S_SQ_RUN, S_MUL, S_CDIV, S_CDIV_RUN, S_CDONE,
		S_WINIT, S_WSQ, S_WDONE, S_BSQ_START, S_BSQ_RUN, S_BDIV, S_BDIV_RUN, S_BDONE,
		S_SMOOTH, S_FINISH
	} state_t;

	state_t state_q;
	logic [1:0] sel_q;
	logic [1:0] smc_q;
	logic       out_valid_q;
	logic       busy_q;
	logic       load_out;

	assign in_ready  = !busy_q;
	assign out_valid = out_valid_q;
	// The finished meter moves to the output register once that register is free.
	assign load_out  = state_q == S_FINISH && (!out_valid_q || out_ready);

	always_comb begin
		ctrl.sqrt_sel = sel_q;
		unique case (state_q)
			S_IDLE:      ctrl.cmd = (in_valid && in_ready && in_op == OpFrame) ? CMD_FRAME : CMD_NONE;
			S_LOAD:      ctrl.cmd = CMD_LOAD;
			S_SQ_START, S_BSQ_START: ctrl.cmd = CMD_SQRT_LR;
			S_SQ_RUN, S_BSQ_RUN, S_WSQ: ctrl.cmd = stat.unit_busy ? CMD_SQRT_STEP : CMD_NONE;
			S_MUL:       ctrl.cmd = CMD_MUL_DEN;
			S_CDIV:      ctrl.cmd = CMD_DIV_COR_INIT;
			S_CDIV_RUN, S_BDIV_RUN: ctrl.cmd = stat.unit_busy ? CMD_DIV_STEP : CMD_NONE;
			S_CDONE:     ctrl.cmd = CMD_COR_DONE;
			S_WINIT:     ctrl.cmd = CMD_WIDTH_INIT;
			S_WDONE:     ctrl.cmd = CMD_WIDTH_DONE;
			S_BDIV:      ctrl.cmd = CMD_BAL_DIV_INIT;
			S_BDONE:     ctrl.cmd = CMD_BAL_DONE;
			S_SMOOTH:    ctrl.cmd = CMD_SMOOTH;
			S_FINISH:    ctrl.cmd = load_out ? CMD_FINISH : CMD_NONE;
			default:     ctrl.cmd = CMD_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sel_q <= '0;
			smc_q <= '0;
			out_valid_q <= 1'b0;
			busy_q <= 1'b0;
		end else begin
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready && in_op == OpTick) begin
						busy_q <= 1'b1;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					sel_q <= 2'd0;
					smc_q <= '0;
					state_q <= stat.have_frames ? S_SQ_START : S_SMOOTH;
				end
				S_SQ_START: state_q <= S_SQ_RUN;
				S_SQ_RUN: begin
					if (!stat.unit_busy) begin
						if (sel_q == 2'd0) begin
							sel_q <= 2'd1;
							state_q <= S_SQ_START;
						end else begin
							state_q <= S_MUL;
						end
					end
				end
				S_MUL:      state_q <= S_CDIV;
				S_CDIV:     state_q <= S_CDIV_RUN;
				S_CDIV_RUN: if (!stat.unit_busy) state_q <= S_CDONE;
				S_CDONE:    state_q <= S_WINIT;
				S_WINIT:    state_q <= S_WSQ;
				S_WSQ:      if (!stat.unit_busy) state_q <= S_WDONE;
				S_WDONE: begin
					sel_q <= 2'd2;
					state_q <= S_BSQ_START;
				end
				S_BSQ_START: state_q <= S_BSQ_RUN;
				S_BSQ_RUN: begin
					if (!stat.unit_busy) begin
						if (sel_q == 2'd2) begin
							sel_q <= 2'd3;
							state_q <= S_BSQ_START;
						end else begin
							state_q <= S_BDIV;
						end
					end
				end
				S_BDIV:     state_q <= S_BDIV_RUN;
				S_BDIV_RUN: if (!stat.unit_busy) state_q <= S_BDONE;
				S_BDONE:    state_q <= S_SMOOTH;
				S_SMOOTH: begin
					smc_q <= smc_q + 2'd1;
					if (smc_q == 2'd2)
						state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (load_out) begin
						busy_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// A waiting result stays until the receiver takes it.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q) else $error("result dropped while stalled");
	// A result appears only when the output register is loaded.
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_FINISH) else $error("stray result");
	// Every state but idle has the busy flag set.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> busy_q) else $error("busy flag mismatch");
endmodule

// File: rtl/scm_cfg_regs.sv
// Configuration registers of the stereo correlation meter.
module scm_cfg_regs (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output logic [15:0] slow_alpha,
	output logic [15:0] fast_alpha
);
	import scm_pkg::*;

	logic [15:0] slow_q, fast_q;

	// Register writes by index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slow_q <= SlowAlphaReset;
			fast_q <= FastAlphaReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegSlowAlpha: slow_q <= cfg_data;
				RegFastAlpha: fast_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign slow_alpha = slow_q;
	assign fast_alpha = fast_q;
endmodule

// File: tb/sv/tb.sv
// Self-checking testbench of the stereo correlation meter: directed and random frames and ticks against a predictor.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import scm_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;  // left_sample[15:0], right_sample[31:16]
	logic        s_axis_tuser = 1'b0;  // op
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;  // width_out[14:0], correlation_out[30:15], balance_out[46:31]
	logic        cfg_we = 1'b0;
	logic [0:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	typedef struct packed {
		logic        op;
		logic [15:0] right;
		logic [15:0] left;
	} beat_t;

	typedef struct packed {
		logic [15:0] bal;
		logic [15:0] cor;
		logic [14:0] wid;
	} meter_t;

	beat_t  pending_beats[$];
	meter_t expected_meters[$];
	int     errors = 0;
	int     ticks_sent = 0;
	int     frames_sent = 0;
	int     quiet_cycles = 0;
	bit     calm = 1'b0;

	// Predictor state.
	logic [15:0]        slow_a, fast_a;
	logic [63:0]        acc_l2, acc_r2;
	logic signed [63:0] acc_lr;
	int                 n_frames;
	int                 sm_w, sm_c, sm_b;

	stereo_correlation_meter DUT (.*);

	always #2 clk = ~clk;

	function automatic logic [63:0] int_sqrt(logic [63:0] v);
		logic [63:0] r, bit_w;
		r = 0;
		bit_w = 64'd1 << 62;
		while (bit_w > v) bit_w >>= 2;
		while (bit_w != 0) begin
			if (v >= r + bit_w) begin
				v -= r + bit_w;
				r = (r >> 1) + bit_w;
			end else begin
				r >>= 1;
			end
			bit_w >>= 2;
		end
		return r;
	endfunction

	function automatic int lift_steps(logic [63:0] v, int lb);
		int k;
		k = 0;
		while (k < 30 && v < (64'd1 << (lb - 2))) begin
			v <<= 2;
			k++;
		end
		return k;
	endfunction

	function automatic int smooth_step(int s, int x, logic [15:0] a, int lo, int hi);
		longint n, q;
		n = longint'(s) * longint'({1'b0, a}) + longint'(x) * (65536 - longint'({1'b0, a}))
			+ 32768;
		q = n >>> 16;
		if (q < lo) q = lo;
		if (q > hi) q = hi;
		return int'(q);
	endfunction

	function automatic int correlation_of();
		int a, b, c;
		logic [63:0] sl, sr, mag, num, den, ip, rem, frac, val;
		if (acc_l2 == 0 || acc_r2 == 0) return 32768;
		a = lift_steps(acc_l2, 60);
		b = lift_steps(acc_r2, 60);
		sl = int_sqrt(acc_l2 << (2 * a));
		sr = int_sqrt(acc_r2 << (2 * b));
		mag = acc_lr < 0 ? 64'(-acc_lr) : 64'(acc_lr);
		num = mag << (a + b);
		den = sl * sr;
		ip = num / den;
		rem = num % den;
		frac = 0;
		for (int i = 0; i < 16; i++) begin
			rem <<= 1;
			frac <<= 1;
			if (rem >= den) begin
				rem -= den;
				frac |= 1;
			end
		end
		if (ip > 1) ip = 1;
		val = ((ip << 16) | frac) + 1;
		val >>= 1;
		if (val > 32768) val = 32768;
		c = int'(val);
		return acc_lr < 0 ? -c : c;
	endfunction

	function automatic int balance_of();
		logic [63:0] m, sl, sr, d, mag;
		int k;
		m = acc_l2 > acc_r2 ? acc_l2 : acc_r2;
		if (m == 0) return 0;
		k = lift_steps(m, 62);
		sl = int_sqrt(acc_l2 << (2 * k));
		sr = int_sqrt(acc_r2 << (2 * k));
		d = sr >= sl ? sr - sl : sl - sr;
		mag = (((d << 16) / (sl + sr)) + 1) >> 1;
		if (mag > 32768) mag = 32768;
		return sr >= sl ? int'(mag) : -int'(mag);
	endfunction

	// Advance the predictor by one accepted beat.
	task automatic predict_meter(beat_t bt);
		longint l, r;
		int cw, cc, cb, raw;
		meter_t m;
		if (bt.op == OpFrame) begin
			if (n_frames < MaxFrames) begin
				l = longint'($signed(bt.left));
				r = longint'($signed(bt.right));
				acc_l2 += 64'(l * l);
				acc_r2 += 64'(r * r);
				acc_lr += l * r;
				n_frames++;
			end
			return;
		end
		cw = 0;
		cc = 32768;
		cb = 0;
		if (n_frames > 0) begin
			cc = correlation_of();
			raw = 32768 - cc;
			if (raw < 0) raw = 0;
			if (raw > 32768) raw = 32768;
			cw = int'((int_sqrt(64'(raw) << 17) + 1) >> 1);
			cb = balance_of();
			acc_l2 = 0;
			acc_r2 = 0;
			acc_lr = 0;
			n_frames = 0;
		end
		sm_w = smooth_step(sm_w, cw, slow_a, 0, 32767);
		sm_c = smooth_step(sm_c, cc, fast_a, -32768, 32767);
		sm_b = smooth_step(sm_b, cb, slow_a, -32768, 32767);
		m.wid = sm_w[14:0];
		m.cor = sm_c[15:0];
		m.bal = sm_b[15:0];
		expected_meters = {expected_meters, m};
	endtask

	// Driver: present queued beats, idling at random outside calm phases.
	always @(posedge clk) begin
		if (arst_n) begin
			if (!s_axis_tvalid || s_axis_tready) begin
				if (s_axis_tvalid) predict_meter(beat_t'({s_axis_tuser, s_axis_tdata}));
				if (pending_beats.size() > 0 && (calm || $urandom_range(99) >= 25)) begin
					beat_t bt;
					bt = pending_beats.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tuser <= bt.op;
					s_axis_tdata <= {bt.right, bt.left};
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each delivered meter beat with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				meter_t got, want;
				got = meter_t'(m_axis_tdata[46:0]);
				if (expected_meters.size() == 0) begin
					$display("%0t: unexpected beat, expected none, actual %h", $time, got);
					errors++;
				end else begin
					want = expected_meters.pop_front();
					if (got.wid !== want.wid) begin
						$display("%0t: width expected %0d actual %0d", $time, want.wid, got.wid);
						errors++;
					end
					if (got.cor !== want.cor) begin
						$display("%0t: correlation expected %0d actual %0d", $time,
							$signed(want.cor), $signed(got.cor));
						errors++;
					end
					if (got.bal !== want.bal) begin
						$display("%0t: balance expected %0d actual %0d", $time,
							$signed(want.bal), $signed(got.bal));
						errors++;
					end
				end
			end
			m_axis_tready <= calm || $urandom_range(99) >= 25;
		end
	end

	// Watchdog on cycles with no accepted beat.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 20000) begin
			$display("stereo_correlation_meter verification failed");
			$finish;
		end
	end

	task automatic add_beat(logic op, logic [15:0] l, logic [15:0] r);
		beat_t bt;
		bt.op = op;
		bt.left = l;
		bt.right = r;
		pending_beats = {pending_beats, bt};
		if (op == OpTick) ticks_sent++;
		else frames_sent++;
	endtask

	task automatic wait_drained();
		while (pending_beats.size() > 0 || s_axis_tvalid || expected_meters.size() > 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic set_reg(logic [0:0] idx, logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == RegSlowAlpha) slow_a = val;
		else fast_a = val;
	endtask

	// Random frames in bursts closed by a tick; the stereo image varies per burst, the amplitude per frame.
	task automatic random_phase(int n_items);
		int mode, len;
		logic [15:0] l, r;
		while (n_items > 0) begin
			len = $urandom_range(40);
			if ($urandom_range(19) == 0) len = 0;
			mode = $urandom_range(5);
			for (int i = 0; i < len; i++) begin
				l = 16'($urandom);
				if (mode == 1) l = $signed(l) >>> $urandom_range(15);
				case (mode)
					0: r = l;
					1: r = -l;
					2: r = 16'($urandom);
					3: r = $signed(l) >>> $urandom_range(6);
					4: r = 16'h0000;
					default: r = 16'($urandom);
				endcase
				if ($urandom_range(1)) add_beat(OpFrame, l, r);
				else add_beat(OpFrame, r, l);
			end
			add_beat(OpTick, 16'($urandom), 16'($urandom));
			n_items -= len + 1;
		end
	endtask

	initial begin
		slow_a = SlowAlphaReset;
		fast_a = FastAlphaReset;
		acc_l2 = 0;
		acc_r2 = 0;
		acc_lr = 0;
		n_frames = 0;
		sm_w = 0;
		sm_c = 0;
		sm_b = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty tick, extremes, mono, anti-phase, silent channels.
		add_beat(OpTick, 16'h0000, 16'h0000);
		add_beat(OpFrame, 16'h8000, 16'h8000);
		add_beat(OpFrame, 16'h7FFF, 16'h7FFF);
		add_beat(OpTick, 16'hFFFF, 16'hFFFF);
		add_beat(OpFrame, 16'h7FFF, 16'h8000);
		add_beat(OpFrame, 16'h8000, 16'h7FFF);
		add_beat(OpTick, 16'h0000, 16'h0000);
		add_beat(OpFrame, 16'h1234, 16'h0000);
		add_beat(OpTick, 16'h0000, 16'h0000);
		add_beat(OpFrame, 16'h0000, 16'hC000);
		add_beat(OpTick, 16'h0000, 16'h0000);
		add_beat(OpFrame, 16'h0000, 16'h0000);
		add_beat(OpFrame, 16'h0001, 16'hFFFF);
		add_beat(OpTick, 16'h0000, 16'h0000);
		add_beat(OpFrame, 16'h0100, 16'h4000);
		add_beat(OpTick, 16'h0000, 16'h0000);
		wait_drained();

		// Phases across coefficient settings, extremes included.
		calm = 1'b1;
		random_phase(150);
		wait_drained();
		calm = 1'b0;
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin set_reg(RegSlowAlpha, 16'h0000); set_reg(RegFastAlpha, 16'hFFFF); end
				1: begin set_reg(RegSlowAlpha, 16'hFFFF); set_reg(RegFastAlpha, 16'h0000); end
				2: begin set_reg(RegSlowAlpha, 16'h0000); set_reg(RegFastAlpha, 16'h0000); end
				3: begin
					set_reg(RegSlowAlpha, 16'($urandom));
					set_reg(RegFastAlpha, 16'($urandom));
				end
				4: begin set_reg(RegSlowAlpha, 16'hFFFF); set_reg(RegFastAlpha, 16'hFFFF); end
				default: begin
					set_reg(RegSlowAlpha, SlowAlphaReset);
					set_reg(RegFastAlpha, FastAlphaReset);
				end
			endcase
			random_phase(200);
			wait_drained();
		end

		$display("Sent %0d frames and %0d ticks over seven coefficient settings,", frames_sent,
			ticks_sent);
		$display("including mono and anti-phase bursts, silent channels and empty ticks.");
		if (errors == 0)
			$display("stereo_correlation_meter verification clean");
		else
			$display("stereo_correlation_meter verification failed");
		$finish;
	end
endmodule

// File: filelist.f
rtl/scm_pkg.sv
rtl/scm_datapath.sv
rtl/scm_controller.sv
rtl/scm_cfg_regs.sv
rtl/stereo_correlation_meter.sv
tb/sv/tb.sv
